[rtl/core/lbpf_pkg.sv]
`default_nettype none

package lbpf_pkg;

   // Port and datapath widths.
   localparam int REQ_TDATA_W = 16;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_USED_W  = 19;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int ELAPSED_W   = 32;
   localparam int LEVEL_W     = 8;
   localparam int MS_W        = 16;
   localparam int COUNT_W     = 8;
   localparam int PERIOD_W    = MS_W + 1;
   localparam int PROD_W      = PERIOD_W + COUNT_W;
   localparam int NUM_W       = MS_W + LEVEL_W;
   localparam int DIV_W       = 32;
   localparam int DIVISOR_W   = 17;
   localparam int DIV_CNT_W   = 5;

   // Defaults and limits.
   localparam logic [MS_W-1:0]    PULSE_DEFAULT_MS = 16'd2000;
   localparam logic [MS_W-1:0]    PULSE_MIN_MS     = 16'd2;
   localparam logic [MS_W-1:0]    FADE_DEFAULT_MS  = 16'd1000;
   localparam logic [MS_W-1:0]    BLINK_ON_RESET   = 16'd500;
   localparam logic [MS_W-1:0]    BLINK_OFF_RESET  = 16'd500;
   localparam logic [COUNT_W-1:0] BLINK_CNT_RESET  = 8'd3;
   localparam logic [LEVEL_W-1:0] FULL_DUTY        = 8'd255;

   typedef enum logic [2:0] {
      OP_TICK      = 3'd0,
      OP_SET_LED   = 3'd1,
      OP_SET_LEVEL = 3'd2,
      OP_BLINK     = 3'd3,
      OP_PULSE     = 3'd4,
      OP_FADE_IN   = 3'd5,
      OP_FADE_OUT  = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      MODE_STATIC = 2'd0,
      MODE_BLINK  = 2'd1,
      MODE_PULSE  = 2'd2,
      MODE_FADE   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CSR_BLINK_ON       = 3'd0,
      CSR_BLINK_OFF      = 3'd1,
      CSR_BLINK_COUNT    = 3'd2,
      CSR_PULSE_PERIOD   = 3'd3,
      CSR_FADE_DURATION  = 3'd4
   } csr_type;

   typedef enum logic [1:0] {
      DIV_SEL_PHASE = 2'd0,
      DIV_SEL_PULSE = 2'd1,
      DIV_SEL_FADE  = 2'd2
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'd0,
      ST_APPLY  = 4'd1,
      ST_DECIDE = 4'd2,
      ST_DIV1   = 4'd3,
      ST_MID    = 4'd4,
      ST_LOAD2  = 4'd5,
      ST_DIV2   = 4'd6,
      ST_FIN    = 4'd7,
      ST_OUTW   = 4'd8
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        capture;
      logic        apply;
      logic        div_start;
      div_sel_type div_sel;
      logic        prep_pulse;
      logic        finish;
      logic        load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic     is_tick;
      mode_type mode;
      logic     blink_zero;
      logic     fade_end;
      logic     div_done;
   } status_type;

endpackage

`default_nettype wire

[rtl/core/lbpf_div.sv]
`default_nettype none

module lbpf_div
   import lbpf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [DIV_W-1:0]     dividend,
   input  wire logic [DIVISOR_W-1:0] divisor,
   output logic      [DIV_W-1:0]     quotient,
   output logic      [DIVISOR_W-1:0] remainder,
   output logic                      done
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dsr_ff, dsr_in;
   logic [DIVISOR_W:0]   partial;
   logic [DIVISOR_W:0]   diff;
   logic                 fits;
   logic                 last;

   // One restoring step: bring down the next dividend bit and try a subtract.
   assign partial = {rem_ff, quo_ff[DIV_W-1]};
   assign diff    = partial - {1'b0, dsr_ff};
   assign fits    = ~diff[DIVISOR_W];
   assign last    = (cnt_ff == DIV_CNT_W'(DIV_W - 1));

   // Load on start, then one quotient bit per cycle, MSB first.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_W-2:0], fits};
         rem_in = fits ? diff[DIVISOR_W-1:0] : partial[DIVISOR_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

`default_nettype wire

[rtl/core/lbpf_dp.sv]
`default_nettype none

module lbpf_dp
   import lbpf_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   output status_type                  status,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic [REQ_TUSER_W-1:0] req_tuser,
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,
   input  wire logic                   csr_we,
   input  wire logic [CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Captured item.
   op_type             op_ff, op_in;
   logic [LEVEL_W-1:0] value_ff, value_in;
   logic               sw_ff, sw_in;

   // Configuration registers.
   logic [MS_W-1:0]    cfg_on_ff, cfg_on_in;
   logic [MS_W-1:0]    cfg_off_ff, cfg_off_in;
   logic [COUNT_W-1:0] cfg_count_ff, cfg_count_in;
   logic [MS_W-1:0]    cfg_period_ff, cfg_period_in;
   logic [MS_W-1:0]    cfg_fade_ff, cfg_fade_in;

   // Settings taken when an animation starts.
   logic [MS_W-1:0]     lat_on_ff, lat_on_in;
   logic [PERIOD_W-1:0] lat_per_ff, lat_per_in;
   logic [COUNT_W-1:0]  lat_count_ff, lat_count_in;
   logic [MS_W-1:0]     lat_period_ff, lat_period_in;
   logic [MS_W-1:0]     lat_fade_ff, lat_fade_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;

   // Engine state.
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   mode_type             mode_ff, mode_in;
   logic                 rising_ff, rising_in;
   logic                 on_ff, on_in;
   logic [LEVEL_W-1:0]   level_ff, level_in;
   logic [LEVEL_W-1:0]   duty_ff, duty_in;
   logic                 prev_ff, prev_in;

   logic [NUM_W-1:0]       num_ff, num_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Divider hookup.
   logic [DIV_W-1:0]     div_dividend;
   logic [DIVISOR_W-1:0] div_divisor;
   logic [DIV_W-1:0]     div_quo;
   logic [DIVISOR_W-1:0] div_rem;
   logic                 div_done;

   logic [MS_W-2:0]    half;
   logic [MS_W-1:0]    phase;
   logic [MS_W-1:0]    tri_x;
   logic [NUM_W-1:0]   pulse_num;
   logic [NUM_W-1:0]   fade_num;
   logic [LEVEL_W-1:0] pulse_duty;
   logic               fade_end;
   logic               blink_zero;

   lbpf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quo),
      .remainder (div_rem),
      .done      (div_done)
   );

   // Helper values for the animations.
   assign half       = lat_period_ff[MS_W-1:1];
   assign phase      = div_rem[MS_W-1:0];
   assign tri_x      = (phase < {1'b0, half}) ? phase : (lat_period_ff - phase);
   assign pulse_num  = {tri_x, {LEVEL_W{1'b0}}} - {{LEVEL_W{1'b0}}, tri_x};
   assign fade_num   = {elapsed_ff[MS_W-1:0], {LEVEL_W{1'b0}}}
                       - {{LEVEL_W{1'b0}}, elapsed_ff[MS_W-1:0]};
   assign pulse_duty = (div_quo[DIV_W-1:LEVEL_W] != '0) ? FULL_DUTY : div_quo[LEVEL_W-1:0];
   assign fade_end   = (elapsed_ff >= {{(ELAPSED_W-MS_W){1'b0}}, lat_fade_ff});
   assign blink_zero = (lat_per_ff == '0);

   // Divider operand selection.
   always_comb begin
      case (cmd.div_sel)
         DIV_SEL_PULSE: begin
            div_dividend = {{(DIV_W-NUM_W){1'b0}}, num_ff};
            div_divisor  = {2'b00, half};
         end
         DIV_SEL_FADE: begin
            div_dividend = {{(DIV_W-NUM_W){1'b0}}, fade_num};
            div_divisor  = {1'b0, lat_fade_ff};
         end
         default: begin
            div_dividend = elapsed_ff;
            div_divisor  = (mode_ff == MODE_BLINK) ? lat_per_ff : {1'b0, lat_period_ff};
         end
      endcase
   end

   // Next state of the datapath registers.
   always_comb begin
      op_in         = op_ff;
      value_in      = value_ff;
      sw_in         = sw_ff;
      cfg_on_in     = cfg_on_ff;
      cfg_off_in    = cfg_off_ff;
      cfg_count_in  = cfg_count_ff;
      cfg_period_in = cfg_period_ff;
      cfg_fade_in   = cfg_fade_ff;
      lat_on_in     = lat_on_ff;
      lat_per_in    = lat_per_ff;
      lat_count_in  = lat_count_ff;
      lat_period_in = lat_period_ff;
      lat_fade_in   = lat_fade_ff;
      prod_in       = PROD_W'(lat_per_ff) * PROD_W'(lat_count_ff);
      elapsed_in    = elapsed_ff;
      mode_in       = mode_ff;
      rising_in     = rising_ff;
      on_in         = on_ff;
      level_in      = level_ff;
      duty_in       = duty_ff;
      prev_in       = prev_ff;
      num_in        = num_ff;
      rsp_data_in   = rsp_data_ff;

      // Take in an accepted beat.
      if (cmd.capture) begin
         op_in    = op_type'(req_tuser);
         value_in = req_tdata[LEVEL_W-1:0];
         sw_in    = req_tdata[LEVEL_W];
      end

      // Register writes; indexes past the list are dropped.
      if (csr_we) begin
         case (csr_type'(csr_addr))
            CSR_BLINK_ON:      cfg_on_in     = csr_wdata;
            CSR_BLINK_OFF:     cfg_off_in    = csr_wdata;
            CSR_BLINK_COUNT:   cfg_count_in  = csr_wdata[COUNT_W-1:0];
            CSR_PULSE_PERIOD:  cfg_period_in = csr_wdata;
            CSR_FADE_DURATION: cfg_fade_in   = csr_wdata;
            default: ;
         endcase
      end

      // First step of every item: the command itself, or the tick bookkeeping.
      if (cmd.apply) begin
         case (op_ff)
            OP_TICK: begin
               if (elapsed_ff != '1) begin
                  elapsed_in = elapsed_ff + 1'b1;
               end
               if (sw_ff && !prev_ff) begin
                  on_in   = ~on_ff;
                  duty_in = on_ff ? '0 : level_ff;
               end
               prev_in = sw_ff;
            end
            OP_SET_LED: begin
               on_in   = (value_ff != '0);
               duty_in = (value_ff != '0) ? level_ff : '0;
            end
            OP_SET_LEVEL: begin
               level_in = value_ff;
               if (on_ff) begin
                  duty_in = value_ff;
               end
            end
            OP_BLINK: begin
               mode_in      = MODE_BLINK;
               lat_on_in    = cfg_on_ff;
               lat_per_in   = {1'b0, cfg_on_ff} + {1'b0, cfg_off_ff};
               lat_count_in = cfg_count_ff;
               elapsed_in   = '0;
               on_in        = 1'b1;
               duty_in      = level_ff;
            end
            OP_PULSE: begin
               mode_in    = MODE_PULSE;
               elapsed_in = '0;
               if (cfg_period_ff == '0) begin
                  lat_period_in = PULSE_DEFAULT_MS;
               end else if (cfg_period_ff < PULSE_MIN_MS) begin
                  lat_period_in = PULSE_MIN_MS;
               end else begin
                  lat_period_in = cfg_period_ff;
               end
            end
            OP_FADE_IN, OP_FADE_OUT: begin
               mode_in     = MODE_FADE;
               rising_in   = (op_ff == OP_FADE_IN);
               lat_fade_in = (cfg_fade_ff == '0) ? FADE_DEFAULT_MS : cfg_fade_ff;
               elapsed_in  = '0;
               on_in       = 1'b1;
            end
            default: ;
         endcase
      end

      // Triangle numerator from the phase remainder.
      if (cmd.prep_pulse) begin
         num_in = pulse_num;
      end

      // Last step of an animation tick.
      if (cmd.finish) begin
         case (mode_ff)
            MODE_BLINK: begin
               if (blink_zero) begin
                  mode_in = MODE_STATIC;
                  duty_in = on_ff ? level_ff : '0;
               end else if (elapsed_ff >= {{(ELAPSED_W-PROD_W){1'b0}}, prod_ff}) begin
                  mode_in = MODE_STATIC;
                  duty_in = on_ff ? level_ff : '0;
               end else begin
                  duty_in = (div_rem < {1'b0, lat_on_ff}) ? level_ff : '0;
               end
            end
            MODE_PULSE: begin
               if (on_ff) begin
                  duty_in = pulse_duty;
               end
            end
            MODE_FADE: begin
               if (fade_end) begin
                  mode_in = MODE_STATIC;
                  if (rising_ff) begin
                     level_in = FULL_DUTY;
                     duty_in  = FULL_DUTY;
                  end else begin
                     level_in = '0;
                     duty_in  = '0;
                     on_in    = 1'b0;
                  end
               end else begin
                  duty_in = rising_ff ? div_quo[LEVEL_W-1:0]
                                      : FULL_DUTY - div_quo[LEVEL_W-1:0];
               end
            end
            default: ;
         endcase
      end

      // Result beat: duty, on flag, mode, level from the lowest bit up.
      if (cmd.load_out) begin
         rsp_data_in = {{(RSP_TDATA_W-RSP_USED_W){1'b0}}, level_ff, mode_ff, on_ff, duty_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_on_ff     <= BLINK_ON_RESET;
         cfg_off_ff    <= BLINK_OFF_RESET;
         cfg_count_ff  <= BLINK_CNT_RESET;
         cfg_period_ff <= '0;
         cfg_fade_ff   <= '0;
         lat_on_ff     <= BLINK_ON_RESET;
         lat_per_ff    <= {1'b0, BLINK_ON_RESET} + {1'b0, BLINK_OFF_RESET};
         lat_count_ff  <= BLINK_CNT_RESET;
         lat_period_ff <= PULSE_DEFAULT_MS;
         lat_fade_ff   <= FADE_DEFAULT_MS;
         elapsed_ff    <= '0;
         mode_ff       <= MODE_STATIC;
         rising_ff     <= 1'b0;
         on_ff         <= 1'b0;
         level_ff      <= FULL_DUTY;
         duty_ff       <= '0;
         prev_ff       <= 1'b0;
      end else begin
         cfg_on_ff     <= cfg_on_in;
         cfg_off_ff    <= cfg_off_in;
         cfg_count_ff  <= cfg_count_in;
         cfg_period_ff <= cfg_period_in;
         cfg_fade_ff   <= cfg_fade_in;
         lat_on_ff     <= lat_on_in;
         lat_per_ff    <= lat_per_in;
         lat_count_ff  <= lat_count_in;
         lat_period_ff <= lat_period_in;
         lat_fade_ff   <= lat_fade_in;
         elapsed_ff    <= elapsed_in;
         mode_ff       <= mode_in;
         rising_ff     <= rising_in;
         on_ff         <= on_in;
         level_ff      <= level_in;
         duty_ff       <= duty_in;
         prev_ff       <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      value_ff    <= value_in;
      sw_ff       <= sw_in;
      prod_ff     <= prod_in;
      num_ff      <= num_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.is_tick    = (op_ff == OP_TICK);
   assign status.mode       = mode_ff;
   assign status.blink_zero = blink_zero;
   assign status.fade_end   = fade_end;
   assign status.div_done   = div_done;
   assign rsp_tdata         = rsp_data_ff;

endmodule

`default_nettype wire

[rtl/core/lbpf_ctrl.sv]
`default_nettype none

module lbpf_ctrl
   import lbpf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire status_type status,
   output cmd_type         cmd,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = ~rsp_valid_ff | rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            state_in = status.is_tick ? ST_DECIDE : ST_OUTW;
         end
         ST_DECIDE: begin
            case (status.mode)
               MODE_BLINK: state_in = status.blink_zero ? ST_FIN : ST_DIV1;
               MODE_PULSE: state_in = ST_DIV1;
               MODE_FADE:  state_in = status.fade_end ? ST_FIN : ST_DIV1;
               default:    state_in = ST_OUTW;
            endcase
         end
         ST_DIV1: begin
            if (status.div_done) begin
               state_in = (status.mode == MODE_PULSE) ? ST_MID : ST_FIN;
            end
         end
         ST_MID: begin
            state_in = ST_LOAD2;
         end
         ST_LOAD2: begin
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            if (status.div_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            state_in = ST_OUTW;
         end
         ST_OUTW: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands and handshake outputs.
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
         end
         ST_DECIDE: begin
            case (status.mode)
               MODE_BLINK: begin
                  cmd.div_start = ~status.blink_zero;
                  cmd.div_sel   = DIV_SEL_PHASE;
               end
               MODE_PULSE: begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = DIV_SEL_PHASE;
               end
               MODE_FADE: begin
                  cmd.div_start = ~status.fade_end;
                  cmd.div_sel   = DIV_SEL_FADE;
               end
               default: ;
            endcase
         end
         ST_MID: begin
            cmd.prep_pulse = 1'b1;
         end
         ST_LOAD2: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_PULSE;
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
         end
         ST_OUTW: begin
            cmd.load_out = out_free;
         end
         default: ;
      endcase
   end

   // Result beat valid: set on load, cleared when taken.
   assign rsp_valid_in = cmd.load_out | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

[rtl/core/led_blink_pulse_fade_engine.sv]
// Each beat is captured and applied. A command then goes to the output register; a tick first
// decides on its mode: static goes to the output, a fade end or a zero-period blink to the finish
// step, and another blink or fade tick runs the divider once, a pulse tick twice (32-step
// bit-serial divider), before the finish. One item is in work at a time; the next item is
// accepted while the previous result still waits in the output register.
// Reset is synchronous and active high: static and off with level 255, registers at defaults.
`default_nettype none

module led_blink_pulse_fade_engine
   import lbpf_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,   // [7:0] value, [8] switch_level
   input  wire logic [REQ_TUSER_W-1:0] req_tuser,   // [2:0] op
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,   // [7:0] duty, [8] led_on, [10:9] mode,
                                                    // [18:11] level
   input  wire logic                   csr_we,
   input  wire logic [CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // Sequencer for each beat.
   lbpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .status     (status),
      .cmd        (cmd),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // Engine state, registers and divider.
   lbpf_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

endmodule

`default_nettype wire

[rtl/core/lbpf_checker.sv]
`default_nettype none

module lbpf_checker
   import lbpf_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // A stalled result beat keeps its valid and its data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // Reset leaves no result beat pending.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat valid after reset");

   // One item at a time: accepting a beat closes the input for the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted twice in a row");

   // Padding above the level field is always zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_TDATA_W-1:RSP_USED_W] == '0)
      else $error("result padding not zero");

endmodule

bind led_blink_pulse_fade_engine lbpf_checker u_lbpf_checker (.*);

`default_nettype wire
